@@ hdl/kit_pkg.sv @@
// shared types and constants of the key intern table
// used by kit_ctrl, kit_datapath, key_intern_table and tb_top; depends on nothing else
`default_nettype none

package kit_pkg;

    // command codes carried in the input tuser
    typedef enum logic [2:0] {
        CMD_INTERN     = 3'd0,
        CMD_READ       = 3'd1,
        CMD_REMOVE_IDX = 3'd2,
        CMD_REMOVE_KEY = 3'd3,
        CMD_CLEAR      = 3'd4
    } kit_cmd_t;

    // result status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_BAD,
        DP_CLEAR,
        DP_READ_ADDR,
        DP_READ_RES,
        DP_SCAN_START,
        DP_SCAN_STEP,
        DP_FOUND,
        DP_FULL,
        DP_INSERT,
        DP_SHIFT_SLOT,
        DP_SHIFT_HIT,
        DP_SHIFT_STEP,
        DP_REMOVE_FIN,
        DP_OUT_LOAD
    } kit_op_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_READ_ADDR,
        S_READ_DATA,
        S_SHIFT,
        S_DONE
    } kit_state_t;

    // datapath status seen by the controller
    typedef struct packed {
        kit_cmd_t cmd;
        logic     count_zero;
        logic     full;
        logic     slot_ok;
        logic     hit;
        logic     scan_last;
        logic     tgt_last;
        logic     shift_last;
        logic     out_free;
    } kit_sts_t;

endpackage

`default_nettype wire

@@ hdl/kit_datapath.sv @@
// datapath of the key intern table: entry memory, entry count, scan and shift
// pointers, result and output registers; depends on kit_pkg
`default_nettype none

module kit_datapath
    import kit_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire kit_op_t     op,
    input  wire logic [2:0]  in_cmd,
    input  wire logic [31:0] in_key,
    input  wire logic [5:0]  in_slot,
    input  wire logic        out_tready,
    output logic             out_tvalid,
    output logic [1:0]       out_status,
    output logic [5:0]       out_slot,
    output logic [31:0]      out_key,
    output logic [6:0]       out_count,
    output kit_sts_t         sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_BITS-1:0] mem [DEPTH];

    // control state
    logic [CW-1:0]       count_reg;
    logic                cv_reg;
    logic                wv_reg;
    logic                out_valid_reg;

    // payload
    kit_cmd_t            cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [5:0]          slot_reg;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       tgt_reg;
    logic [AW-1:0]       cmp_ptr_reg;
    logic [KEY_BITS-1:0] rdata_reg;
    logic [1:0]          res_status_reg;
    logic [AW-1:0]       res_slot_reg;
    logic [KEY_BITS-1:0] res_key_reg;
    logic [1:0]          out_status_reg;
    logic [5:0]          out_slot_reg;
    logic [31:0]         out_key_reg;
    logic [6:0]          out_count_reg;

    logic [CW-1:0]       count_m1;
    logic [AW-1:0]       slot_addr;
    logic                we;
    logic [AW-1:0]       wa;
    logic [KEY_BITS-1:0] wd;
    logic                out_free;

    assign count_m1  = count_reg - CW'(1);
    assign slot_addr = AW'(slot_reg);
    assign out_free  = !out_valid_reg || out_tready;

    // shift writes one place below the entry just read; insert appends at the count
    assign we = wv_reg || (op == DP_INSERT);
    assign wa = wv_reg ? (cmp_ptr_reg - AW'(1)) : AW'(count_reg);
    assign wd = wv_reg ? rdata_reg : key_reg;

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.count_zero = (count_reg == '0);
        sts.full       = (count_reg == CW'(DEPTH));
        sts.slot_ok    = ((CW + 6)'(slot_reg) < (CW + 6)'(count_reg));
        sts.hit        = cv_reg && (rdata_reg == key_reg);
        sts.scan_last  = cv_reg && (CW'(cmp_ptr_reg) == count_m1);
        sts.tgt_last   = (CW'(tgt_reg) == count_m1);
        sts.shift_last = wv_reg && (CW'(cmp_ptr_reg) == count_m1);
        sts.out_free   = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg   <= mem[ptr_reg];
        cmp_ptr_reg <= ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cv_reg        <= 1'b0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cv_reg <= (op == DP_SCAN_STEP);
            wv_reg <= (op == DP_SHIFT_STEP);
            case (op)
                DP_CLEAR:      count_reg <= '0;
                DP_INSERT:     count_reg <= count_reg + CW'(1);
                DP_REMOVE_FIN: count_reg <= count_m1;
                default:       count_reg <= count_reg;
            endcase
            if (op == DP_OUT_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            DP_LATCH:
            begin
                cmd_reg  <= kit_cmd_t'(in_cmd);
                key_reg  <= KEY_BITS'(in_key);
                slot_reg <= in_slot;
            end
            DP_BAD, DP_FULL:
            begin
                res_status_reg <= (op == DP_FULL) ? ST_FULL : ST_BAD;
                res_slot_reg   <= '0;
                res_key_reg    <= '0;
            end
            DP_CLEAR:
            begin
                res_status_reg <= ST_DONE;
                res_slot_reg   <= '0;
                res_key_reg    <= '0;
            end
            DP_READ_ADDR:
            begin
                ptr_reg <= slot_addr;
            end
            DP_READ_RES:
            begin
                res_status_reg <= ST_DONE;
                res_slot_reg   <= ptr_reg;
                res_key_reg    <= rdata_reg;
            end
            DP_SCAN_START:
            begin
                ptr_reg <= '0;
            end
            DP_SCAN_STEP, DP_SHIFT_STEP:
            begin
                ptr_reg <= ptr_reg + AW'(1);
            end
            DP_FOUND:
            begin
                res_status_reg <= ST_DONE;
                res_slot_reg   <= cmp_ptr_reg;
                res_key_reg    <= '0;
            end
            DP_INSERT:
            begin
                res_status_reg <= ST_INSERTED;
                res_slot_reg   <= AW'(count_reg);
                res_key_reg    <= '0;
            end
            DP_SHIFT_SLOT:
            begin
                tgt_reg <= slot_addr;
                ptr_reg <= slot_addr + AW'(1);
            end
            DP_SHIFT_HIT:
            begin
                tgt_reg <= cmp_ptr_reg;
                ptr_reg <= cmp_ptr_reg + AW'(1);
            end
            DP_REMOVE_FIN:
            begin
                res_status_reg <= ST_DONE;
                res_slot_reg   <= tgt_reg;
                res_key_reg    <= '0;
            end
            DP_OUT_LOAD:
            begin
                out_status_reg <= res_status_reg;
                out_slot_reg   <= 6'(res_slot_reg);
                out_key_reg    <= 32'(res_key_reg);
                out_count_reg  <= 7'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign out_tvalid = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_key    = out_key_reg;
    assign out_count  = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (op == DP_INSERT) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the count");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(wv_reg && (op == DP_INSERT)))
        else $error("shift write and insert in the same cycle");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((op == DP_REMOVE_FIN) || (op == DP_SHIFT_STEP)) |-> (count_reg != '0))
        else $error("removal from an empty table");

endmodule

`default_nettype wire

@@ hdl/kit_ctrl.sv @@
// controller of the key intern table: sequences each command over the datapath
// depends on kit_pkg
`default_nettype none

module kit_ctrl
    import kit_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_tvalid,
    output logic          in_tready,
    input  wire kit_sts_t sts,
    output kit_op_t       op
);

    kit_state_t state_reg;
    kit_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = DP_NONE;
        in_tready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid)
                begin
                    op         = DP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                case (sts.cmd)
                    CMD_INTERN:
                    begin
                        if (sts.count_zero)
                        begin
                            op = DP_INSERT;
                        end
                        else
                        begin
                            op         = DP_SCAN_START;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_REMOVE_KEY:
                    begin
                        if (sts.count_zero)
                        begin
                            op = DP_BAD;
                        end
                        else
                        begin
                            op         = DP_SCAN_START;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_READ:
                    begin
                        if (sts.slot_ok)
                        begin
                            op         = DP_READ_ADDR;
                            state_next = S_READ_ADDR;
                        end
                        else
                        begin
                            op = DP_BAD;
                        end
                    end
                    CMD_REMOVE_IDX:
                    begin
                        if (sts.slot_ok)
                        begin
                            op         = DP_SHIFT_SLOT;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            op = DP_BAD;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        op = DP_CLEAR;
                    end
                    default:
                    begin
                        op = DP_BAD;
                    end
                endcase
            end
            S_SCAN:
            begin
                // a hit takes priority over reaching the last entry
                if (sts.hit)
                begin
                    if (sts.cmd == CMD_INTERN)
                    begin
                        op         = DP_FOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        op         = DP_SHIFT_HIT;
                        state_next = S_SHIFT;
                    end
                end
                else if (sts.scan_last)
                begin
                    state_next = S_DONE;
                    if (sts.cmd == CMD_INTERN)
                    begin
                        op = sts.full ? DP_FULL : DP_INSERT;
                    end
                    else
                    begin
                        op = DP_BAD;
                    end
                end
                else
                begin
                    op = DP_SCAN_STEP;
                end
            end
            S_READ_ADDR:
            begin
                state_next = S_READ_DATA;
            end
            S_READ_DATA:
            begin
                op         = DP_READ_RES;
                state_next = S_DONE;
            end
            S_SHIFT:
            begin
                if (sts.tgt_last || sts.shift_last)
                begin
                    op         = DP_REMOVE_FIN;
                    state_next = S_DONE;
                end
                else
                begin
                    op = DP_SHIFT_STEP;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    op         = DP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/key_intern_table.sv @@
// Key intern table: a packed table of unique keys kept in first-interned order
// in a single-port-read entry memory. One command word in gives one result word
// out. Read sets the address and then takes the data from the memory. Intern
// walks the valid entries one per cycle through the memory read port until a
// hit or the last entry, and inserts at once on an empty table. Remove by index
// shifts the entries above the slot down by one place; remove by key searches,
// then shifts when the key is found. Both the search and the shift are paced
// by the one read port of the entry memory. A new command word is taken only
// once the previous one has finished; the result register lets it be taken
// while the previous result waits, and a finished command holds in its done
// state for as long as that register is still full. No clearing pass after
// reset.
// depends on kit_pkg, kit_ctrl and kit_datapath
`default_nettype none

module key_intern_table
    import kit_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // key[31:0], slot[37:32], zero pad
    input  wire logic [2:0]  s_axis_tuser,  // cmd[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // slot_out[5:0], key_out[37:6],
                                            // count_out[44:38], zero pad
    output logic [1:0]       m_axis_tuser   // status[1:0]
);

    kit_op_t     op;
    kit_sts_t    sts;
    logic [5:0]  res_slot;
    logic [31:0] res_key;
    logic [6:0]  res_count;

    kit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .sts       (sts),
        .op        (op)
    );

    kit_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .in_cmd     (s_axis_tuser),
        .in_key     (s_axis_tdata[31:0]),
        .in_slot    (s_axis_tdata[37:32]),
        .out_tready (m_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_slot   (res_slot),
        .out_key    (res_key),
        .out_count  (res_count),
        .sts        (sts)
    );

    assign m_axis_tdata = {3'd0, res_count, res_key, res_slot};

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking bench for key_intern_table: a shadow key table predicts every
// result word, stream driver and monitor stall at random; needs kit_pkg and the rtl
`default_nettype none

module tb_top;
    import kit_pkg::*;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 32;
    localparam int POOL_SZ  = 96;

    // codes outside the command set, answered as rejected
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] key;
        logic [5:0]  slot;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot_out;
        logic [31:0] key_out;
        logic [6:0]  count_out;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    cmd_word_t   cmd_backlog[$];
    answer_t     due_answers[$];
    logic [31:0] shadow_keys[DEPTH];
    int          shadow_count = 0;
    logic [31:0] key_pool[POOL_SZ];
    int          mismatches = 0;
    int          feed_gap = 0;
    int          drain_stall = 0;
    logic        steady_flow = 1'b0;
    cmd_word_t   next_cmd;

    key_intern_table #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #14_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic int find_shadow(logic [31:0] k);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_keys[i] == k)
                return i;
        return shadow_count;
    endfunction

    function automatic void drop_shadow(int idx);
        for (int i = idx; i + 1 < shadow_count; i++)
            shadow_keys[i] = shadow_keys[i + 1];
        shadow_count--;
        shadow_keys[shadow_count] = '0;
    endfunction

    // updates the shadow table and queues the answer the block owes
    function automatic void apply_command(logic [2:0] cmd, logic [31:0] k, logic [5:0] slot);
        answer_t a;
        int      idx;
        a = '{status: ST_BAD, slot_out: '0, key_out: '0, count_out: '0};
        case (cmd)
            CMD_INTERN:
            begin
                idx = find_shadow(k);
                if (idx < shadow_count)
                begin
                    a.status   = ST_DONE;
                    a.slot_out = idx[5:0];
                end
                else if (shadow_count >= DEPTH)
                    a.status = ST_FULL;
                else
                begin
                    shadow_keys[shadow_count] = k;
                    a.slot_out = shadow_count[5:0];
                    a.status   = ST_INSERTED;
                    shadow_count++;
                end
            end
            CMD_READ:
            begin
                if (slot < shadow_count)
                begin
                    a.status   = ST_DONE;
                    a.slot_out = slot;
                    a.key_out  = shadow_keys[slot];
                end
            end
            CMD_REMOVE_IDX:
            begin
                if (slot < shadow_count)
                begin
                    drop_shadow(slot);
                    a.status   = ST_DONE;
                    a.slot_out = slot;
                end
            end
            CMD_REMOVE_KEY:
            begin
                idx = find_shadow(k);
                if (idx < shadow_count)
                begin
                    drop_shadow(idx);
                    a.status   = ST_DONE;
                    a.slot_out = idx[5:0];
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < DEPTH; i++)
                    shadow_keys[i] = '0;
                shadow_count = 0;
                a.status = ST_DONE;
            end
            default:
                a.status = ST_BAD;
        endcase
        a.count_out = shadow_count[6:0];
        due_answers.push_back(a);
    endfunction

    function automatic void check_answer();
        answer_t want;
        answer_t got;
        got.status    = m_axis_tuser;
        got.slot_out  = m_axis_tdata[5:0];
        got.key_out   = m_axis_tdata[37:6];
        got.count_out = m_axis_tdata[44:38];
        if (due_answers.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: status %0d slot %0d key %h count %0d",
                         got.status, got.slot_out, got.key_out, got.count_out);
            return;
        end
        want = due_answers.pop_front();
        if (got.status != want.status || got.slot_out != want.slot_out ||
            got.key_out != want.key_out || got.count_out != want.count_out)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: want status %0d slot %0d key %h count %0d, got status %0d slot %0d key %h count %0d",
                         want.status, want.slot_out, want.key_out, want.count_out,
                         got.status, got.slot_out, got.key_out, got.count_out);
        end
    endfunction

    // input side: holds a word until taken, then an optional gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            feed_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                apply_command(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[37:32]);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (feed_gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    feed_gap      <= feed_gap - 1;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    next_cmd = cmd_backlog.pop_front();
                    s_axis_tdata  <= {2'b00, next_cmd.slot, next_cmd.key};
                    s_axis_tuser  <= next_cmd.cmd;
                    s_axis_tvalid <= 1'b1;
                    feed_gap      <= pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side: checks each word taken, stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            drain_stall   <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_answer();
            if (drain_stall != 0)
            begin
                m_axis_tready <= 1'b0;
                drain_stall   <= drain_stall - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    drain_stall <= pick_gap();
            end
        end
    end

    task automatic push_cmd(logic [2:0] cmd, logic [31:0] k, logic [5:0] slot);
        cmd_word_t w;
        w.cmd  = cmd;
        w.key  = k;
        w.slot = slot;
        cmd_backlog.push_back(w);
    endtask

    function automatic logic [5:0] pick_slot();
        if (shadow_count > 0 && $urandom_range(0, 9) < 8)
            return 6'($urandom_range(0, shadow_count - 1));
        return 6'($urandom_range(0, 63));
    endfunction

    initial
    begin
        int          span;
        int          w_intern;
        int          r;
        logic [31:0] k;
        for (int i = 0; i < POOL_SZ; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;

        @(posedge rst_n);

        // empty table, extremes, shift down, reserved codes, clear
        push_cmd(CMD_READ,       32'h0,         6'd0);
        push_cmd(CMD_REMOVE_IDX, 32'h0,         6'd0);
        push_cmd(CMD_REMOVE_KEY, 32'h0,         6'd0);
        push_cmd(CMD_INTERN,     32'h0,         6'd63);
        push_cmd(CMD_INTERN,     32'hFFFF_FFFF, 6'd0);
        push_cmd(CMD_INTERN,     32'h0,         6'd0);
        push_cmd(CMD_INTERN,     32'hA5A5_A5A5, 6'd0);
        push_cmd(CMD_READ,       32'hFFFF_FFFF, 6'd1);
        push_cmd(CMD_READ,       32'h0,         6'd63);
        push_cmd(CMD_READ,       32'h0,         6'd3);
        push_cmd(CMD_REMOVE_KEY, 32'h0,         6'd0);
        push_cmd(CMD_READ,       32'h0,         6'd0);
        push_cmd(CMD_REMOVE_IDX, 32'h0,         6'd1);
        for (logic [3:0] c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++)
            push_cmd(c[2:0], 32'hFFFF_FFFF, 6'd63);
        push_cmd(CMD_INTERN,     32'h5A5A_5A5A, 6'd0);
        push_cmd(CMD_CLEAR,      32'hFFFF_FFFF, 6'd63);
        push_cmd(CMD_READ,       32'h0,         6'd0);
        push_cmd(CMD_REMOVE_KEY, 32'hFFFF_FFFF, 6'd0);
        push_cmd(CMD_INTERN,     32'hFFFF_FFFF, 6'd0);

        // phases: first one fills the table, later ones vary the key spread
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph % 3)
                0: span = POOL_SZ;
                1: span = 16;
                default: span = 4;
            endcase
            w_intern    = (ph == 0) ? 80 : 45;
            steady_flow = (ph == 2);
            for (int n = 0; n < 200; n++)
            begin
                while (cmd_backlog.size() > 1)
                    @(posedge clk);
                r = $urandom_range(0, 99);
                k = ($urandom_range(0, 9) < 9) ? key_pool[$urandom_range(0, span - 1)] : $urandom;
                if (r < w_intern)
                    push_cmd(CMD_INTERN, k, 6'($urandom_range(0, 63)));
                else if (r < w_intern + 20)
                    push_cmd(CMD_READ, $urandom, pick_slot());
                else if (r < w_intern + 30)
                    push_cmd(CMD_REMOVE_IDX, $urandom, pick_slot());
                else if (r < w_intern + 42 && r < 98)
                    push_cmd(CMD_REMOVE_KEY, k, 6'($urandom_range(0, 63)));
                else if (r < 98)
                    push_cmd(CMD_INTERN, k, 6'($urandom_range(0, 63)));
                else if (r == 98)
                    push_cmd(CMD_CLEAR, $urandom, 6'($urandom_range(0, 63)));
                else
                    push_cmd(3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), $urandom,
                             6'($urandom_range(0, 63)));
            end
        end
        steady_flow = 1'b0;

        while (cmd_backlog.size() != 0 || s_axis_tvalid || due_answers.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && due_answers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
